[sv/pt2d_pkg.sv]
package pt2d_pkg;

  // Coordinate and fixed-point format
  localparam int COORD_BITS     = 24;
  localparam int TRIG_FRAC_BITS = 14;

  // Register widths
  localparam int MODE_W = 4;
  localparam int COEF_W = 16;
  localparam int OFFS_W = 15;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Datapath widths: coordinate minus window origin, product, sum of two products plus offset
  localparam int OPND_W = COORD_BITS + 1;
  localparam int PROD_W = OPND_W + COEF_W;
  localparam int SUM_W  = PROD_W + 2;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_MOVE   = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SCALE  = 4'd1;
  localparam logic [MODE_W-1:0] MODE_SHEAR  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_REF_X  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_REF_Y  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_REF_O  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_REF_XY = 4'd6;
  localparam logic [MODE_W-1:0] MODE_REF_NX = 4'd7;
  localparam logic [MODE_W-1:0] MODE_ROTATE = 4'd8;
  localparam logic [MODE_W-1:0] MODE_MAP    = 4'd9;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POST_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POST_Y = 3'd6;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
  } in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         clipped;
  } out_t;

  typedef struct packed {
    logic        [MODE_W-1:0] mode;
    logic signed [COEF_W-1:0] coef_x;
    logic signed [COEF_W-1:0] coef_y;
    logic signed [OFFS_W-1:0] pre_x;
    logic signed [OFFS_W-1:0] pre_y;
    logic signed [OFFS_W-1:0] post_x;
    logic signed [OFFS_W-1:0] post_y;
  } cfg_t;

endpackage

[sv/pt2d_cfg.sv]
module pt2d_cfg
  import pt2d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode   <= MODE_MOVE;
      regs.coef_x <= COEF_W'(1);
      regs.coef_y <= COEF_W'(1);
      regs.pre_x  <= '0;
      regs.pre_y  <= '0;
      regs.post_x <= '0;
      regs.post_y <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE:   regs.mode   <= wr_data[MODE_W-1:0];
        REG_COEF_X: regs.coef_x <= wr_data[COEF_W-1:0];
        REG_COEF_Y: regs.coef_y <= wr_data[COEF_W-1:0];
        REG_PRE_X:  regs.pre_x  <= wr_data[OFFS_W-1:0];
        REG_PRE_Y:  regs.pre_y  <= wr_data[OFFS_W-1:0];
        REG_POST_X: regs.post_x <= wr_data[OFFS_W-1:0];
        REG_POST_Y: regs.post_y <= wr_data[OFFS_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

[sv/pt2d_datapath.sv]
module pt2d_datapath
  import pt2d_pkg::*;
(
  input  cfg_t regs,
  input  in_t  pt,
  output out_t res
);

  localparam logic signed [SUM_W-1:0] C_MAX =
    {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] C_MIN = ~C_MAX;
  localparam int ROUND_BIAS = (1 << TRIG_FRAC_BITS) - 1;

  // Divide by 2^TRIG_FRAC_BITS, truncating toward zero
  function automatic logic signed [SUM_W-1:0] div_trunc(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] b;
    b = v[SUM_W-1] ? v + SUM_W'(ROUND_BIAS) : v;
    return b >>> TRIG_FRAC_BITS;
  endfunction

  logic signed [COORD_BITS-1:0] x, y;
  logic signed [OPND_W-1:0]     ax, ay;
  logic signed [COEF_W-1:0]     cb, cc;
  logic signed [PROD_W-1:0]     m0, m1, m2, m3;
  logic signed [SUM_W-1:0]      sx, sy;
  logic                         clip_x, clip_y;

  assign x = pt.in_x;
  assign y = pt.in_y;

  // Operand selection: window origin only in map mode, coefficient swap for shear/rotate
  assign ax = (regs.mode == MODE_MAP) ? OPND_W'(x) - OPND_W'(regs.pre_x) : OPND_W'(x);
  assign ay = (regs.mode == MODE_MAP) ? OPND_W'(y) - OPND_W'(regs.pre_y) : OPND_W'(y);
  assign cb = (regs.mode == MODE_SHEAR)  ? regs.coef_x : regs.coef_y;
  assign cc = (regs.mode == MODE_ROTATE) ? regs.coef_x : regs.coef_y;

  // Four multiplier lanes
  assign m0 = PROD_W'(ax) * PROD_W'(regs.coef_x);
  assign m1 = PROD_W'(y)  * PROD_W'(cb);
  assign m2 = PROD_W'(ay) * PROD_W'(cc);
  assign m3 = PROD_W'(x)  * PROD_W'(regs.coef_y);

  always_comb begin
    sx = SUM_W'(x);
    sy = SUM_W'(y);
    case (regs.mode)
      MODE_MOVE: begin
        sx = SUM_W'(x) + SUM_W'(regs.post_x);
        sy = SUM_W'(y) + SUM_W'(regs.post_y);
      end
      MODE_SCALE: begin
        sx = SUM_W'(m0);
        sy = SUM_W'(m2);
      end
      MODE_SHEAR: begin
        sx = SUM_W'(x) + SUM_W'(m1) + SUM_W'(regs.post_x);
        sy = SUM_W'(y) + SUM_W'(m3) + SUM_W'(regs.post_y);
      end
      MODE_REF_X:  sy = -SUM_W'(y);
      MODE_REF_Y:  sx = -SUM_W'(x);
      MODE_REF_O: begin
        sx = -SUM_W'(x);
        sy = -SUM_W'(y);
      end
      MODE_REF_XY: begin
        sx = SUM_W'(y);
        sy = SUM_W'(x);
      end
      MODE_REF_NX: begin
        sx = -SUM_W'(y);
        sy = -SUM_W'(x);
      end
      MODE_ROTATE: begin
        sx = div_trunc(SUM_W'(m0) - SUM_W'(m1));
        sy = div_trunc(SUM_W'(m2) + SUM_W'(m3));
      end
      MODE_MAP: begin
        sx = SUM_W'(m0) + SUM_W'(regs.post_x);
        sy = SUM_W'(m2) + SUM_W'(regs.post_y);
      end
      default: ;  // unused codes pass the point through
    endcase
  end

  // Saturation to the coordinate range
  always_comb begin
    clip_x = 1'b0;
    clip_y = 1'b0;
    if (sx > C_MAX) begin
      res.out_x = C_MAX[COORD_BITS-1:0];
      clip_x    = 1'b1;
    end else if (sx < C_MIN) begin
      res.out_x = C_MIN[COORD_BITS-1:0];
      clip_x    = 1'b1;
    end else begin
      res.out_x = sx[COORD_BITS-1:0];
    end
    if (sy > C_MAX) begin
      res.out_y = C_MAX[COORD_BITS-1:0];
      clip_y    = 1'b1;
    end else if (sy < C_MIN) begin
      res.out_y = C_MIN[COORD_BITS-1:0];
      clip_y    = 1'b1;
    end else begin
      res.out_y = sy[COORD_BITS-1:0];
    end
    res.clipped = clip_x | clip_y;
  end

endmodule

[sv/point_transform_2d.sv]
// 2D point transform: each item is one signed point (in_x, in_y) and yields exactly one
// result item with the transformed, saturated point and a clipped flag. The mode register
// selects move, scale, shear with offset, one of five reflections, rotation by Q2.14
// cosine/sine (coef_x/coef_y, sums truncated toward zero) or window-to-viewport mapping
// (p - pre) * coef + post; codes 10..15 pass the point through. Throughput is one item per
// cycle while out_ready is high. The input and result registers bracket the four parallel
// multipliers, the adders and the saturation logic; out_valid rises when the item moves into
// the result register. Configuration writes are always accepted (cfg_ready is tied high) and
// should only be issued while no items are in flight; indexes 7 and up are ignored.
module point_transform_2d
  import pt2d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // point input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t regs;
  in_t  s1_data;
  logic s1_valid;
  out_t dp_res;
  logic out_free;
  logic adv;

  assign cfg_ready = 1'b1;

  pt2d_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  pt2d_datapath u_dp (
    .regs (regs),
    .pt   (s1_data),
    .res  (dp_res)
  );

  // Two-stage pipeline: input register, then result register. The result register frees up
  // whenever its item is taken, so the input stage can keep moving under back-to-back flow.
  assign out_free = ~out_valid | out_ready;
  assign adv      = s1_valid & out_free;
  assign in_ready = ~s1_valid | out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (out_free) out_valid <= s1_valid;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid & in_ready) s1_data <= in_data;
    if (adv) out_data <= dp_res;
  end

endmodule

[tb/point_transform_2d_check.sv]
`timescale 1ns / 1ps

module point_transform_2d_check
  import pt2d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_t                  out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    points_in_flight
);

  // Shadow copy of the register file, sign extended to 64 bits
  logic [MODE_W-1:0] mode_r;
  longint            coef_x_r, coef_y_r, pre_x_r, pre_y_r, post_x_r, post_y_r;

  out_t expected_points[$];

  // Returns {clipped, value} for one coordinate
  function automatic logic [COORD_BITS:0] saturate(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return {1'b1, hi[COORD_BITS-1:0]};
    if (v < lo) return {1'b1, lo[COORD_BITS-1:0]};
    return {1'b0, v[COORD_BITS-1:0]};
  endfunction

  // Coordinates are 24 bits and coefficients 16, so every sum stays well under
  // 48 bits and plain 64-bit math matches the saturating one.
  function automatic out_t transform_point(in_t p);
    longint               x, y, rx, ry, unit;
    logic [COORD_BITS:0]  sx, sy;
    out_t                 r;
    x    = longint'($signed(p.in_x));
    y    = longint'($signed(p.in_y));
    unit = longint'(1) <<< TRIG_FRAC_BITS;
    rx   = x;
    ry   = y;
    case (mode_r)
      MODE_MOVE: begin
        rx = x + post_x_r;
        ry = y + post_y_r;
      end
      MODE_SCALE: begin
        rx = x * coef_x_r;
        ry = y * coef_y_r;
      end
      MODE_SHEAR: begin
        rx = x + y * coef_x_r + post_x_r;
        ry = y + x * coef_y_r + post_y_r;
      end
      MODE_REF_X:  ry = -y;
      MODE_REF_Y:  rx = -x;
      MODE_REF_O: begin
        rx = -x;
        ry = -y;
      end
      MODE_REF_XY: begin
        rx = y;
        ry = x;
      end
      MODE_REF_NX: begin
        rx = -y;
        ry = -x;
      end
      MODE_ROTATE: begin
        // signed division truncates toward zero
        rx = (x * coef_x_r - y * coef_y_r) / unit;
        ry = (y * coef_x_r + x * coef_y_r) / unit;
      end
      MODE_MAP: begin
        rx = (x - pre_x_r) * coef_x_r + post_x_r;
        ry = (y - pre_y_r) * coef_y_r + post_y_r;
      end
      default: ;  // unused codes pass the point through
    endcase
    sx        = saturate(rx);
    sy        = saturate(ry);
    r.out_x   = sx[COORD_BITS-1:0];
    r.out_y   = sy[COORD_BITS-1:0];
    r.clipped = sx[COORD_BITS] | sy[COORD_BITS];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      mode_r   = MODE_MOVE;
      coef_x_r = 1;
      coef_y_r = 1;
      pre_x_r  = 0;
      pre_y_r  = 0;
      post_x_r = 0;
      post_y_r = 0;
      expected_points.delete();
    end else begin
      // compare first, so an item accepted at this edge cannot match itself
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result x=%0d y=%0d clipped=%0b", $time,
                     $signed(out_data.out_x), $signed(out_data.out_y), out_data.clipped);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
              out_data.clipped !== want.clipped) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected x=%0d y=%0d clipped=%0b, got x=%0d y=%0d clipped=%0b",
                       $time, $signed(want.out_x), $signed(want.out_y), want.clipped,
                       $signed(out_data.out_x), $signed(out_data.out_y), out_data.clipped);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_points.push_back(transform_point(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:   mode_r   = cfg_data[MODE_W-1:0];
          REG_COEF_X: coef_x_r = longint'($signed(cfg_data[COEF_W-1:0]));
          REG_COEF_Y: coef_y_r = longint'($signed(cfg_data[COEF_W-1:0]));
          REG_PRE_X:  pre_x_r  = longint'($signed(cfg_data[OFFS_W-1:0]));
          REG_PRE_Y:  pre_y_r  = longint'($signed(cfg_data[OFFS_W-1:0]));
          REG_POST_X: post_x_r = longint'($signed(cfg_data[OFFS_W-1:0]));
          REG_POST_Y: post_y_r = longint'($signed(cfg_data[OFFS_W-1:0]));
          default: ;
        endcase
      end
    end
    points_in_flight = expected_points.size();
  end

endmodule

[tb/point_transform_2d_test.sv]
`timescale 1ns / 1ps

module point_transform_2d_test;
  import pt2d_pkg::*;

  // Run length and watchdog
  localparam int RANDOM_POINTS  = 700;
  localparam int CALM_TAIL      = 100;   // last points run with no idling on either side
  localparam int WATCHDOG_LIMIT = 500;   // cycles with no item moving on any channel
  localparam int PIPE_DRAIN     = 4;     // margin after the pipe is empty

  // Codes the block does not define; it must pass the point through
  localparam logic [MODE_W-1:0]    MODE_UNUSED_LO = 4'd10;
  localparam logic [MODE_W-1:0]    MODE_UNUSED_HI = 4'd15;
  // Index with no register behind it; the write must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE       = 3'd7;

  localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches;
  int points_in_flight;

  // Random gaps on the sender and stalls on the receiver while this is set
  bit idle_on = 1'b1;
  int out_stall = 0;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  reg_write_t pending_writes[$];

  always #5 clk = ~clk;

  point_transform_2d uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  point_transform_2d_check check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .points_in_flight (points_in_flight)
  );

  // Receiver: random stall bursts, no new ones once idling is off
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      out_stall = $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // All drive tasks start and end on a falling edge. Valid is raised at the
  // start of a transfer and only lowered by a gap or by the caller, so a
  // back-to-back item never sees valid dropped and raised in one step.

  task automatic send_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    in_valid <= 1'b1;
    in_data  <= '{in_x: x, in_y: y};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  function automatic void stage(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    pending_writes.push_back('{idx, data});
  endfunction

  // Registers change only with the pipe empty: wait out every result, give
  // the datapath the PIPE_DRAIN margin, then push the staged writes.
  task automatic apply_writes();
    in_valid <= 1'b0;
    while (points_in_flight != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
    foreach (pending_writes[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= pending_writes[i].idx;
      cfg_data  <= pending_writes[i].data;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        cfg_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
    cfg_valid <= 1'b0;
    pending_writes.delete();
  endtask

  // Mix of extremes, full-width noise and small values that rarely clip
  function automatic logic [COORD_BITS-1:0] random_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return COORD_MAX;
          1:       return COORD_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3, 4: return COORD_BITS'($urandom);
      default:    return COORD_BITS'($urandom_range(0, 4000) - 2000);
    endcase
  endfunction

  // Coefficients span -16384..16384, offsets -10000..10000; raw noise now and
  // then puts values outside that and sets the unused top bit of offsets.
  function automatic logic [CFG_DATA_W-1:0] random_reg_value(input logic [CFG_IDX_W-1:0] idx);
    bit is_coef;
    is_coef = (idx == REG_COEF_X || idx == REG_COEF_Y);
    case ($urandom_range(0, 9))
      0:       return is_coef ? CFG_DATA_W'(-16384) : CFG_DATA_W'(-10000);
      1:       return is_coef ? CFG_DATA_W'(16384)  : CFG_DATA_W'(10000);
      2:       return '0;
      3:       return CFG_DATA_W'($urandom);
      default: return is_coef ? CFG_DATA_W'($urandom_range(0, 32768) - 16384)
                              : CFG_DATA_W'($urandom_range(0, 20000) - 10000);
    endcase
  endfunction

  // Watchdog: ends the run if nothing moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (!rst);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** point_transform_2d: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int                sent;
    int                n;
    logic [MODE_W-1:0] m;

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed part ----

    // Reset registers: move with zero offsets, full-scale corners
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN);

    // Move with offsets at the 15-bit extremes; the first point clips both ways
    stage(REG_MODE, CFG_DATA_W'(MODE_MOVE));
    stage(REG_POST_X, CFG_DATA_W'(16383));
    stage(REG_POST_Y, CFG_DATA_W'(-16384));
    apply_writes();
    send_point(COORD_MAX, COORD_MIN);
    send_point(COORD_BITS'(-5), COORD_BITS'(7));

    // Scale by the 16-bit extremes: one within the limits (y exactly at the minimum), one just past
    stage(REG_MODE, CFG_DATA_W'(MODE_SCALE));
    stage(REG_COEF_X, CFG_DATA_W'(32767));
    stage(REG_COEF_Y, CFG_DATA_W'(-32768));
    apply_writes();
    send_point(COORD_BITS'(256), COORD_BITS'(256));
    send_point(COORD_BITS'(257), COORD_BITS'(-257));

    // Shear with offset
    stage(REG_MODE, CFG_DATA_W'(MODE_SHEAR));
    stage(REG_COEF_X, CFG_DATA_W'(3));
    stage(REG_COEF_Y, CFG_DATA_W'(-2));
    stage(REG_POST_X, CFG_DATA_W'(100));
    stage(REG_POST_Y, CFG_DATA_W'(-100));
    apply_writes();
    send_point(COORD_BITS'(1000), COORD_BITS'(-2000));

    // Every reflection on the most negative point: each negation must saturate
    for (int k = MODE_REF_X; k <= MODE_REF_NX; k++) begin
      stage(REG_MODE, CFG_DATA_W'(k));
      apply_writes();
      send_point(COORD_MIN, COORD_MIN);
    end

    // Rotation: identity at cos 1.0, then 45 degrees where the negative sums
    // must truncate toward zero rather than round down
    stage(REG_MODE, CFG_DATA_W'(MODE_ROTATE));
    stage(REG_COEF_X, CFG_DATA_W'(16384));
    stage(REG_COEF_Y, '0);
    apply_writes();
    send_point(COORD_MIN, COORD_MAX);
    stage(REG_COEF_X, CFG_DATA_W'(11585));
    stage(REG_COEF_Y, CFG_DATA_W'(11585));
    apply_writes();
    send_point(COORD_BITS'(-3), COORD_BITS'(1));

    // Window-to-viewport map with window origin at the 15-bit extremes
    stage(REG_MODE, CFG_DATA_W'(MODE_MAP));
    stage(REG_COEF_X, CFG_DATA_W'(2));
    stage(REG_COEF_Y, CFG_DATA_W'(-3));
    stage(REG_PRE_X, CFG_DATA_W'(16383));
    stage(REG_PRE_Y, CFG_DATA_W'(-16384));
    stage(REG_POST_X, CFG_DATA_W'(-10000));
    stage(REG_POST_Y, CFG_DATA_W'(10000));
    apply_writes();
    send_point(COORD_MIN, COORD_MAX);
    send_point(COORD_BITS'(20000), COORD_BITS'(-20000));

    // Unused codes pass through; a write to the missing index changes nothing
    stage(REG_MODE, CFG_DATA_W'(MODE_UNUSED_LO));
    stage(REG_NONE, '1);
    apply_writes();
    send_point(COORD_MIN, COORD_MAX);
    stage(REG_MODE, CFG_DATA_W'(MODE_UNUSED_HI));
    apply_writes();
    send_point(COORD_MAX, COORD_MIN);

    // ---- random part: one register setting per phase ----
    sent = 0;
    while (sent < RANDOM_POINTS) begin
      idle_on = (sent < RANDOM_POINTS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      m = ($urandom_range(0, 7) == 0) ? MODE_W'($urandom_range(10, 15))
                                      : MODE_W'($urandom_range(0, 9));
      // upper data bits of the mode write are noise the block must drop
      stage(REG_MODE, {(CFG_DATA_W-MODE_W)'($urandom), m});
      for (int r = REG_COEF_X; r <= REG_POST_Y; r++)
        if ($urandom_range(0, 3) != 0)
          stage(CFG_IDX_W'(r), random_reg_value(CFG_IDX_W'(r)));
      if ($urandom_range(0, 9) == 0)
        stage(REG_NONE, CFG_DATA_W'($urandom));
      apply_writes();

      n = $urandom_range(10, 40);
      for (int k = 0; k < n; k++) begin
        send_point(random_coord(), random_coord());
        maybe_gap();
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (points_in_flight != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0)
      $display("** point_transform_2d: PASSED **");
    else
      $display("** point_transform_2d: FAILED **");
    $finish;
  end

endmodule
